// ----- rtl/wak_pkg.sv -----
// ----------------------------------------------------------------------------
// wak_pkg
// shared constants and helpers for the websocket accept key block
// ----------------------------------------------------------------------------
package wak_pkg;

	localparam int MSG_BUF_BYTES = 256;
	localparam int GUID_LEN      = 36;
	localparam int ACCEPT_CHARS  = 28;

	localparam logic [31:0] IV0 = 32'h67452301;
	localparam logic [31:0] IV1 = 32'hEFCDAB89;
	localparam logic [31:0] IV2 = 32'h98BADCFE;
	localparam logic [31:0] IV3 = 32'h10325476;
	localparam logic [31:0] IV4 = 32'hC3D2E1F0;

	localparam logic [8*GUID_LEN-1:0] GUID_TEXT = "258EAFA5-E914-47DA-95CA-C5AB0DC85B11";

	// command from controller to datapath
	typedef struct packed {
		logic       init;      // load iv, clear count
		logic       wr_byte;   // write byte into block buffer
		logic [7:0] wr_data;
		logic       count;     // bump message length on this write
		logic [5:0] wr_addr;
		logic       start;     // load round vars from the chain, clear round index
		logic       round;     // run one round
		logic       finish;    // add round vars into chain
		logic [4:0] out_idx;   // base64 character index
	} wak_cmd_t;

	function automatic logic [7:0] guid_byte(input logic [5:0] idx);
		return GUID_TEXT[8*(GUID_LEN-1-int'(idx)) +: 8];
	endfunction

	function automatic logic [6:0] b64_char(input logic [5:0] v);
		logic [6:0] r;
		if (v < 6'd26)      r = 7'd65 + {1'b0, v};
		else if (v < 6'd52) r = 7'd71 + {1'b0, v};
		else if (v < 6'd62) r = {1'b0, v} - 7'd4;
		else if (v == 6'd62) r = 7'd43;
		else                 r = 7'd47;
		return r;
	endfunction

endpackage

// ----- rtl/wak_datapath.sv -----
// ----------------------------------------------------------------------------
// wak_datapath
// message words, sha-1 round unit, chain hash and base64 character select
// ----------------------------------------------------------------------------
module wak_datapath #(
	parameter int LEN_W = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  wak_pkg::wak_cmd_t cmd,
	output logic [LEN_W-1:0]  msg_len,
	output logic [6:0]        out_char
);

	// block bytes land straight in the schedule window, big-endian per word
	logic [31:0] h_q [5];
	logic [31:0] a_q, b_q, c_q, d_q, e_q;
	logic [31:0] w_q [16];
	logic [6:0]  t_q;
	logic [LEN_W-1:0] len_q;

	logic [31:0] wx, wt, fn, kc, sum;
	logic [159:0] dig;
	logic [167:0] digx;
	logic [5:0]   sext;

	assign msg_len = len_q;

	always_comb begin
		wx = w_q[4'(t_q+7'd13)] ^ w_q[4'(t_q+7'd8)] ^ w_q[4'(t_q+7'd2)] ^ w_q[t_q[3:0]];
		wt = (t_q >= 7'd16) ? {wx[30:0], wx[31]} : w_q[t_q[3:0]];
		if (t_q < 7'd20) begin
			fn = (b_q & c_q) | (~b_q & d_q); kc = 32'h5A827999;
		end else if (t_q < 7'd40) begin
			fn = b_q ^ c_q ^ d_q; kc = 32'h6ED9EBA1;
		end else if (t_q < 7'd60) begin
			fn = (b_q & c_q) | (b_q & d_q) | (c_q & d_q); kc = 32'h8F1BBCDC;
		end else begin
			fn = b_q ^ c_q ^ d_q; kc = 32'hCA62C1D6;
		end
		sum = {a_q[26:0], a_q[31:27]} + fn + e_q + kc + wt;
		dig  = {h_q[0], h_q[1], h_q[2], h_q[3], h_q[4]};
		digx = {dig, 8'h00};
		sext = digx[167 - 6*int'(cmd.out_idx) -: 6];
		out_char = (cmd.out_idx == 5'(wak_pkg::ACCEPT_CHARS-1)) ? 7'd61
			: wak_pkg::b64_char(sext);
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_byte) begin
			w_q[cmd.wr_addr[5:2]][8*(3-int'(cmd.wr_addr[1:0])) +: 8] <= cmd.wr_data;
		end else if (cmd.round) begin
			w_q[t_q[3:0]] <= wt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			h_q[0] <= wak_pkg::IV0; h_q[1] <= wak_pkg::IV1; h_q[2] <= wak_pkg::IV2;
			h_q[3] <= wak_pkg::IV3; h_q[4] <= wak_pkg::IV4;
			a_q <= '0; b_q <= '0; c_q <= '0; d_q <= '0; e_q <= '0;
			t_q <= '0;
			len_q <= '0;
		end else begin
			if (cmd.init) begin
				h_q[0] <= wak_pkg::IV0; h_q[1] <= wak_pkg::IV1; h_q[2] <= wak_pkg::IV2;
				h_q[3] <= wak_pkg::IV3; h_q[4] <= wak_pkg::IV4;
				len_q <= '0;
			end else if (cmd.wr_byte && cmd.count) begin
				len_q <= len_q + 1'b1;
			end
			if (cmd.start) begin
				a_q <= h_q[0]; b_q <= h_q[1]; c_q <= h_q[2]; d_q <= h_q[3]; e_q <= h_q[4];
				t_q <= '0;
			end else if (cmd.round) begin
				e_q <= d_q; d_q <= c_q; c_q <= {b_q[1:0], b_q[31:2]};
				b_q <= a_q; a_q <= sum;
				t_q <= t_q + 7'd1;
			end
			if (cmd.finish) begin
				h_q[0] <= h_q[0] + a_q; h_q[1] <= h_q[1] + b_q; h_q[2] <= h_q[2] + c_q;
				h_q[3] <= h_q[3] + d_q; h_q[4] <= h_q[4] + e_q;
			end
		end
	end

endmodule

// ----- rtl/wak_ctrl.sv -----
// ----------------------------------------------------------------------------
// wak_ctrl
// sequencer: byte intake, guid append, padding, rounds and character output
// ----------------------------------------------------------------------------
module wak_ctrl #(
	parameter int MSG_BUF_BYTES = wak_pkg::MSG_BUF_BYTES,
	parameter int LEN_W = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  logic [7:0]        key_byte,
	input  logic              has_byte,
	input  logic              key_last,
	output logic              out_valid,
	input  logic              out_stall,
	output logic              char_last,
	input  logic [LEN_W-1:0]  msg_len,
	output wak_pkg::wak_cmd_t cmd
);

	typedef enum logic [2:0] {
		S_IDLE, S_GUID, S_PAD, S_START, S_ROUND, S_FINISH, S_OUT
	} state_t;

	localparam logic [LEN_W-1:0] CAP = LEN_W'(MSG_BUF_BYTES - 1);

	state_t     state_q, ret_q;
	logic [5:0] gi_q;      // guid index / pad address
	logic [6:0] rc_q;
	logic       len_done_q; // length block written
	logic [4:0] oi_q;

	logic       room;
	logic [63:0] bitlen;
	logic [5:0]  pos;

	assign room = msg_len < CAP;
	assign pos  = msg_len[5:0];
	assign bitlen = 64'(msg_len) << 3;
	assign in_stall  = (state_q != S_IDLE);
	assign out_valid = (state_q == S_OUT);
	assign char_last = (oi_q == 5'(wak_pkg::ACCEPT_CHARS-1));

	always_comb begin
		cmd = '0;
		cmd.out_idx = oi_q;
		unique case (state_q)
			S_IDLE: begin
				cmd.wr_byte = in_valid && has_byte && room;
				cmd.count   = 1'b1;
				cmd.wr_data = key_byte;
				cmd.wr_addr = pos;
			end
			S_GUID: begin
				cmd.wr_byte = room;
				cmd.count   = 1'b1;
				cmd.wr_data = wak_pkg::guid_byte(gi_q);
				cmd.wr_addr = pos;
			end
			S_PAD: begin
				// gi_q walks the block; 0x80 at pos, zeros, then length bytes
				cmd.wr_byte = 1'b1;
				cmd.wr_addr = gi_q;
				if (!len_done_q && gi_q == pos) cmd.wr_data = 8'h80;
				else if (!len_done_q && gi_q < pos) cmd.wr_data = 8'h00;
				else if (gi_q >= 6'd56 && (len_done_q || pos < 6'd56))
					cmd.wr_data = bitlen[63 - 8*int'(gi_q[2:0]) -: 8];
				else cmd.wr_data = 8'h00;
				if (!len_done_q && gi_q < pos) cmd.wr_byte = 1'b0;
			end
			S_START:  cmd.start  = 1'b1;
			S_ROUND:  cmd.round  = 1'b1;
			S_FINISH: cmd.finish = 1'b1;
			S_OUT:    cmd.init   = !out_stall && char_last;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE; ret_q <= S_IDLE;
			gi_q <= '0; rc_q <= '0; len_done_q <= 1'b0; oi_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: if (in_valid) begin
					gi_q <= '0;
					if (cmd.wr_byte && pos == 6'd63) begin
						state_q <= S_START; ret_q <= key_last ? S_GUID : S_IDLE;
					end else if (key_last) state_q <= S_GUID;
				end
				S_GUID: begin
					// the padding sweep starts from address zero
					gi_q <= (gi_q == 6'(wak_pkg::GUID_LEN-1)) ? 6'd0 : gi_q + 6'd1;
					if (cmd.wr_byte && pos == 6'd63) begin
						state_q <= S_START;
						ret_q <= (gi_q == 6'(wak_pkg::GUID_LEN-1)) ? S_PAD : S_GUID;
					end else if (gi_q == 6'(wak_pkg::GUID_LEN-1)) state_q <= S_PAD;
					if (gi_q == 6'(wak_pkg::GUID_LEN-1)) len_done_q <= 1'b0;
				end
				S_PAD: begin
					gi_q <= gi_q + 6'd1;
					if (gi_q == 6'd63) begin
						state_q <= S_START;
						if (!len_done_q && pos >= 6'd56) begin
							ret_q <= S_PAD; len_done_q <= 1'b1;
						end else ret_q <= S_OUT;
					end
				end
				S_START: begin
					rc_q <= '0; state_q <= S_ROUND;
				end
				S_ROUND: begin
					rc_q <= rc_q + 7'd1;
					if (rc_q == 7'd79) state_q <= S_FINISH;
				end
				S_FINISH: begin
					state_q <= ret_q; oi_q <= '0;
					if (ret_q == S_PAD || ret_q == S_OUT) gi_q <= '0;
					if (ret_q == S_GUID) gi_q <= gi_q;
				end
				S_OUT: if (!out_stall) begin
					if (char_last) begin
						state_q <= S_IDLE; oi_q <= '0; len_done_q <= 1'b0;
					end else oi_q <= oi_q + 5'd1;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ----- rtl/websocket_accept_key_top.sv -----
// ----------------------------------------------------------------------------
// websocket_accept_key_top
// sha-1 of key plus handshake guid, emitted as 28 base64 characters
// ----------------------------------------------------------------------------
//  channel | signals                                  | direction
//  in      | in_valid in_stall key_byte has_byte key_last | item in
//  out     | out_valid out_stall accept_char char_last    | item out
//
// a key byte is taken whenever input is not stalled; the byte that fills
// a 64-byte block stalls input for the load, 80 rounds on the one shared
// round unit and the chain add
// on the last item: guid append, padding sweep per tail block, load,
// rounds and chain add per block compressed, then 28 characters, one per
// cycle unless stalled
// reset loads the sha-1 initial values; no clearing pass is needed
// input is stalled from the last item until the final character is taken
module websocket_accept_key_top #(
	parameter int MSG_BUF_BYTES = wak_pkg::MSG_BUF_BYTES,
	parameter int LEN_W = $clog2(MSG_BUF_BYTES)
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] key_byte,
	input  logic       has_byte,
	input  logic       key_last,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [6:0] accept_char,
	output logic       char_last
);

	wak_pkg::wak_cmd_t cmd;
	logic [LEN_W-1:0]  msg_len;

	// sequencer
	wak_ctrl #(.MSG_BUF_BYTES(MSG_BUF_BYTES), .LEN_W(LEN_W)) u_ctrl (
		.clk, .arst_n, .in_valid, .in_stall, .key_byte, .has_byte, .key_last,
		.out_valid, .out_stall, .char_last, .msg_len, .cmd
	);

	// hash datapath and character select
	wak_datapath #(.LEN_W(LEN_W)) u_dp (
		.clk, .arst_n, .cmd, .msg_len, .out_char(accept_char)
	);

endmodule

// ----- sim/tb_websocket_accept_key_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_websocket_accept_key_top
// checks the accept key block against a sha-1 plus base64 model run in the
// bench; keys of many lengths, empty items, empty and overlong keys
// ----------------------------------------------------------------------------

// holds the characters still to come and compares each one that arrives
class accept_scoreboard;
	logic [7:0] key_q[$];
	logic [6:0] char_q[$];
	bit         clast_q[$];
	int         errors;
	int         keys_done;
	int         chars_seen;

	function automatic logic [31:0] rol(logic [31:0] x, int n);
		return (x << n) | (x >> (32 - n));
	endfunction

	function automatic logic [6:0] b64(logic [5:0] v);
		string abc;
		byte   ch;
		abc = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
		ch = abc[v];
		return ch[6:0];
	endfunction

	// full sha-1 of the kept message, then base64 into the char queue
	function automatic void hash_key();
		logic [7:0]  msg[$];
		logic [7:0]  blk[64];
		logic [31:0] h[5];
		logic [31:0] w[80];
		logic [31:0] a, b, c, d, e, f, k, t;
		logic [63:0] bits;
		logic [7:0]  dg[20];
		logic [23:0] v;
		string guid;
		int nblk;
		guid = "258EAFA5-E914-47DA-95CA-C5AB0DC85B11";
		foreach (key_q[i]) if (msg.size() < 255) msg.push_back(key_q[i]);
		for (int i = 0; i < 36; i++) if (msg.size() < 255) msg.push_back(guid[i]);
		bits = msg.size() * 8;
		msg.push_back(8'h80);
		while (msg.size() % 64 != 56) msg.push_back(8'h00);
		for (int i = 7; i >= 0; i--) msg.push_back(bits[8*i +: 8]);
		h[0] = wak_pkg::IV0; h[1] = wak_pkg::IV1; h[2] = wak_pkg::IV2;
		h[3] = wak_pkg::IV3; h[4] = wak_pkg::IV4;
		nblk = msg.size() / 64;
		for (int bi = 0; bi < nblk; bi++) begin
			for (int i = 0; i < 64; i++) blk[i] = msg[bi*64 + i];
			for (int i = 0; i < 16; i++)
				w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
			for (int i = 16; i < 80; i++)
				w[i] = rol(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
			a = h[0]; b = h[1]; c = h[2]; d = h[3]; e = h[4];
			for (int i = 0; i < 80; i++) begin
				if (i < 20) begin
					f = (b & c) | (~b & d); k = 32'h5A827999;
				end else if (i < 40) begin
					f = b ^ c ^ d; k = 32'h6ED9EBA1;
				end else if (i < 60) begin
					f = (b & c) | (b & d) | (c & d); k = 32'h8F1BBCDC;
				end else begin
					f = b ^ c ^ d; k = 32'hCA62C1D6;
				end
				t = rol(a, 5) + f + e + k + w[i];
				e = d; d = c; c = rol(b, 30); b = a; a = t;
			end
			h[0] += a; h[1] += b; h[2] += c; h[3] += d; h[4] += e;
		end
		for (int i = 0; i < 20; i++) dg[i] = h[i/4][8*(3 - i%4) +: 8];
		for (int g = 0; g < 18; g += 3) begin
			v = {dg[g], dg[g+1], dg[g+2]};
			for (int j = 3; j >= 0; j--) begin
				char_q.push_back(b64(v[6*j +: 6])); clast_q.push_back(0);
			end
		end
		v = {dg[18], dg[19], 8'h00};
		for (int j = 3; j >= 1; j--) begin
			char_q.push_back(b64(v[6*j +: 6])); clast_q.push_back(0);
		end
		char_q.push_back(7'd61); clast_q.push_back(1);
		key_q.delete();
		keys_done++;
	endfunction

	function void note_item(logic [7:0] kb, logic hb, logic kl);
		if (hb) key_q.push_back(kb);
		if (kl) hash_key();
	endfunction

	function void check_char(logic [6:0] ch, logic cl);
		chars_seen++;
		if (char_q.size() == 0) begin
			$display("%0t: unexpected char %h last %b", $time, ch, cl);
			errors++;
			return;
		end
		if (ch !== char_q[0] || cl !== clast_q[0]) begin
			$display("%0t: mismatch expected char %h last %b, actual char %h last %b",
				$time, char_q[0], clast_q[0], ch, cl);
			errors++;
		end
		void'(char_q.pop_front());
		void'(clast_q.pop_front());
	endfunction
endclass

module tb_websocket_accept_key_top;
	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_stall;
	logic [7:0] key_byte;
	logic       has_byte;
	logic       key_last;
	logic       out_valid;
	logic       out_stall;
	logic [6:0] accept_char;
	logic       char_last;

	accept_scoreboard sb;
	int  cycles;
	int  items_sent;
	bit  stall_hard;   // receiver stall pattern mode

	localparam int CYCLE_LIMIT = 1000000;

	websocket_accept_key_top u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.key_byte(key_byte), .has_byte(has_byte), .key_last(key_last),
		.out_valid(out_valid), .out_stall(out_stall),
		.accept_char(accept_char), .char_last(char_last)
	);

	// clock
	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	// receiver: stall pattern switches between long free runs and heavy stalls
	initial begin
		out_stall = 0;
		stall_hard = 0;
		forever begin
			@(posedge clk);
			if ($urandom_range(0, 63) == 0) stall_hard <= ~stall_hard;
			if (stall_hard) out_stall <= ($urandom_range(0, 3) != 0);
			else out_stall <= ($urandom_range(0, 7) == 0);
		end
	end

	// check every accepted character; sampled at the edge, before nba updates
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) sb.check_char(accept_char, char_last);
	end

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// burst state of the sender
	int burst_left;

	// send one item; valid stays high inside a burst, gaps fall between bursts
	task automatic send_item(logic [7:0] kb, logic hb, logic kl);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 3) == 0 ? $urandom_range(1, 12) : 0;
			if (gap > 0) begin
				in_valid <= 0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 40);
		end
		in_valid <= 1;
		key_byte <= kb;
		has_byte <= hb;
		key_last <= kl;
		// wait for the accepting edge
		do @(posedge clk); while (in_stall);
		sb.note_item(kb, hb, kl);
		items_sent++;
		burst_left--;
	endtask

	// whole key of n bytes, with optional empty items sprinkled in
	task automatic send_key(int n, bit noise, int fixed_byte);
		logic [7:0] b;
		for (int i = 0; i < n; i++) begin
			if (noise && $urandom_range(0, 9) == 0)
				send_item(8'($urandom), 1'b0, 1'b0);
			b = fixed_byte >= 0 ? fixed_byte[7:0] : 8'($urandom);
			send_item(b, 1'b1, (i == n - 1) && !noise);
		end
		if (noise || n == 0) send_item(8'($urandom), 1'b0, 1'b1);
	endtask

	initial begin
		int n;
		int idle;
		sb = new();
		items_sent = 0;
		burst_left = 0;
		arst_n = 0;
		in_valid = 0;
		key_byte = 0;
		has_byte = 0;
		key_last = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: empty keys, one zero byte, three all-ones bytes, block boundary lengths
		send_key(0, 1'b0, -1);
		send_item(8'h00, 1'b0, 1'b0);     // empty item changes nothing
		send_item(8'hFF, 1'b0, 1'b1);     // then an empty key
		send_key(1, 1'b0, 8'h00);
		send_key(3, 1'b0, 8'hFF);
		send_key(19, 1'b0, -1);           // 55 bytes with guid, one block
		send_key(20, 1'b0, -1);           // 56 bytes, padding spills a block

		// random keys: mostly short, some long enough to truncate the guid
		while (items_sent < 450) begin
			case ($urandom_range(0, 9))
				0:       n = $urandom_range(200, 300);   // overlong
				1:       n = $urandom_range(25, 30);     // block boundary region
				default: n = $urandom_range(0, 32);
			endcase
			if (n > 450 - items_sent) n = 450 - items_sent;
			send_key(n, $urandom_range(0, 2) == 0, -1);
		end
		in_valid <= 0;

		// drain, then a short idle window for stray output
		while (sb.char_q.size() != 0) @(posedge clk);
		idle = 0;
		while (idle < 200) begin
			@(posedge clk);
			idle++;
		end

		$display("sent %0d items over %0d keys, checked %0d characters",
			items_sent, sb.keys_done, sb.chars_seen);
		if (sb.errors == 0 && sb.char_q.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end
endmodule
